// ----- src/qvr_pkg.sv -----
package qvr_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int NUM_PARTS  = 4;

  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  // four products, negation of the most negative product, rounding constant
  localparam int ACC_WIDTH  = PROD_WIDTH + 3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [ACC_WIDTH-1:0]  acc_t;

  localparam acc_t SAT_MAX = acc_t'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam acc_t SAT_MIN = -SAT_MAX - acc_t'(1);
  localparam acc_t HALF    = acc_t'(64'sd1 <<< (FRAC_BITS - 1));

  // Part index order: x, y, z, w.
  localparam int PART_W = 3;

  // Hamilton product r = a * b: result part k takes a[j] * b[B_IDX[k][j]].
  localparam logic [1:0] B_IDX [NUM_PARTS][NUM_PARTS] = '{
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd0, 2'd1, 2'd2, 2'd3}
  };

  // Terms subtracted rather than added.
  localparam logic NEG [NUM_PARTS][NUM_PARTS] = '{
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b1, 1'b0}
  };

  // Operands entering a product stage.
  typedef struct {
    data_t a [NUM_PARTS];
    data_t b [NUM_PARTS];
    data_t q [NUM_PARTS];
    logic  clip;
  } mul_beat_t;

  // All sixteen partial products, a index first.
  typedef struct {
    prod_t p [NUM_PARTS][NUM_PARTS];
    data_t q [NUM_PARTS];
    logic  clip;
  } prod_beat_t;

  // Rounded, saturated quaternion.
  typedef struct {
    data_t r [NUM_PARTS];
    data_t q [NUM_PARTS];
    logic  clip;
  } part_beat_t;

endpackage

// ----- src/qvr_in_if.sv -----
interface qvr_in_if import qvr_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t rot_x;
  data_t rot_y;
  data_t rot_z;
  data_t rot_w;
  data_t vec_x;
  data_t vec_y;
  data_t vec_z;

  modport source (
    output valid, rot_x, rot_y, rot_z, rot_w, vec_x, vec_y, vec_z,
    input  ready
  );

  modport sink (
    input  valid, rot_x, rot_y, rot_z, rot_w, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

// ----- src/qvr_out_if.sv -----
interface qvr_out_if import qvr_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t out_x;
  data_t out_y;
  data_t out_z;
  data_t out_w;
  logic  clipped;

  modport source (
    output valid, out_x, out_y, out_z, out_w, clipped,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, out_w, clipped,
    output ready
  );
endinterface

// ----- src/qvr_mul_stage.sv -----
module qvr_mul_stage import qvr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mul_beat_t  in_beat_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output prod_beat_t out_beat_o
);

  logic       v_q;
  prod_beat_t beat_q;
  prod_beat_t beat_d;
  logic       load;

  assign in_ready_o = !v_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // 16 independent signed multiplies
  always_comb begin
    for (int i = 0; i < NUM_PARTS; i++) begin
      for (int j = 0; j < NUM_PARTS; j++) begin
        beat_d.p[i][j] = prod_t'(in_beat_i.a[i]) * prod_t'(in_beat_i.b[j]);
      end
      beat_d.q[i] = in_beat_i.q[i];
    end
    beat_d.clip = in_beat_i.clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_beat_o  = beat_q;

endmodule

// ----- src/qvr_sum_stage.sv -----
module qvr_sum_stage import qvr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       conj_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  prod_beat_t in_beat_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output part_beat_t out_beat_o
);

  logic       v_q;
  part_beat_t beat_q;
  part_beat_t beat_d;
  logic       load;
  logic       sat_any;
  acc_t       acc [NUM_PARTS];
  acc_t       sh  [NUM_PARTS];

  assign in_ready_o = !v_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // conj_i: b operand is conj(b), so x/y/z columns flip sign
  always_comb begin
    acc_t term;
    logic neg;
    sat_any = 1'b0;
    for (int k = 0; k < NUM_PARTS; k++) begin
      acc[k] = HALF;
      for (int j = 0; j < NUM_PARTS; j++) begin
        term = acc_t'(in_beat_i.p[j][B_IDX[k][j]]);
        neg  = NEG[k][j] ^ (conj_i && (B_IDX[k][j] != 2'(PART_W)));
        if (neg) begin
          acc[k] = acc[k] - term;
        end else begin
          acc[k] = acc[k] + term;
        end
      end
      sh[k] = acc[k] >>> FRAC_BITS;
      if (sh[k] > SAT_MAX) begin
        beat_d.r[k] = data_t'(SAT_MAX);
        sat_any     = 1'b1;
      end else if (sh[k] < SAT_MIN) begin
        beat_d.r[k] = data_t'(SAT_MIN);
        sat_any     = 1'b1;
      end else begin
        beat_d.r[k] = data_t'(sh[k]);
      end
      beat_d.q[k] = in_beat_i.q[k];
    end
    beat_d.clip = in_beat_i.clip || sat_any;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_beat_o  = beat_q;

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> v_q)
    else $error("loaded beat not presented");

  a_clip_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && in_beat_i.clip |=> beat_q.clip)
    else $error("upstream clip flag dropped");

  a_clip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !in_beat_i.clip && !sat_any |=> !beat_q.clip)
    else $error("clip set without saturation");

endmodule

// ----- src/quaternion_vector_rotate_core.sv -----
// Rotates a 3-vector by a quaternion: out = q * (v,0) * conj(q). Quaternion parts are
// signed Q1.14, vector and result parts signed 16-bit in the vector's scale. Every part
// of both Hamilton products is rounded to nearest (half up), shifted right by 14 and
// saturated to 16 bits; clipped reports any saturation, in the intermediate product
// too. No normalization is done. The core takes one beat per cycle unless backpressure
// has filled its stages; each accepted beat passes through multiply, sum/round, multiply,
// sum/round, each a register stage with its own valid bit. Backpressure stalls only the
// stages that are full, so bubbles are squeezed out and nothing is lost or repeated.
module quaternion_vector_rotate_core import qvr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  qvr_in_if.sink       in_i,
  qvr_out_if.source    out_o
);

  mul_beat_t  m1_in;
  prod_beat_t m1_out;
  part_beat_t s1_out;
  mul_beat_t  m2_in;
  prod_beat_t m2_out;
  part_beat_t s2_out;

  logic m1_valid, m1_ready;
  logic s1_valid, s1_ready;
  logic m2_valid, m2_ready;
  logic s2_valid;

  // first product: q * (v, 0)
  always_comb begin
    m1_in.a[0] = in_i.rot_x;
    m1_in.a[1] = in_i.rot_y;
    m1_in.a[2] = in_i.rot_z;
    m1_in.a[3] = in_i.rot_w;
    m1_in.b[0] = in_i.vec_x;
    m1_in.b[1] = in_i.vec_y;
    m1_in.b[2] = in_i.vec_z;
    m1_in.b[3] = '0;
    for (int i = 0; i < NUM_PARTS; i++) begin
      m1_in.q[i] = m1_in.a[i];
    end
    m1_in.clip = 1'b0;
  end

  qvr_mul_stage u_mul1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_beat_i   (m1_in),
    .out_valid_o (m1_valid),
    .out_ready_i (m1_ready),
    .out_beat_o  (m1_out)
  );

  qvr_sum_stage u_sum1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .conj_i      (1'b0),
    .in_valid_i  (m1_valid),
    .in_ready_o  (m1_ready),
    .in_beat_i   (m1_out),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .out_beat_o  (s1_out)
  );

  // second product: t * conj(q); the conjugate signs are folded into u_sum2
  always_comb begin
    for (int i = 0; i < NUM_PARTS; i++) begin
      m2_in.a[i] = s1_out.r[i];
      m2_in.b[i] = s1_out.q[i];
      m2_in.q[i] = s1_out.q[i];
    end
    m2_in.clip = s1_out.clip;
  end

  qvr_mul_stage u_mul2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_beat_i   (m2_in),
    .out_valid_o (m2_valid),
    .out_ready_i (m2_ready),
    .out_beat_o  (m2_out)
  );

  qvr_sum_stage u_sum2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .conj_i      (1'b1),
    .in_valid_i  (m2_valid),
    .in_ready_o  (m2_ready),
    .in_beat_i   (m2_out),
    .out_valid_o (s2_valid),
    .out_ready_i (out_o.ready),
    .out_beat_o  (s2_out)
  );

  assign out_o.valid   = s2_valid;
  assign out_o.out_x   = s2_out.r[0];
  assign out_o.out_y   = s2_out.r[1];
  assign out_o.out_z   = s2_out.r[2];
  assign out_o.out_w   = s2_out.r[3];
  assign out_o.clipped = s2_out.clip;

endmodule
